### hdl/smps_pkg.sv
package smps_pkg;

    localparam int AdcWidth   = 12;
    localparam int ScaleWidth = 10;
    localparam int LevelWidth = 11;
    localparam int CountWidth = 16;
    localparam int CfgWidth   = 16;
    localparam int CfgIdxWidth = 2;

    localparam logic [ScaleWidth-1:0] ScaleReset   = ScaleWidth'(330);
    localparam logic [LevelWidth-1:0] OnThrReset   = LevelWidth'(485);
    localparam logic [LevelWidth-1:0] OffThrReset  = LevelWidth'(475);
    localparam logic [CountWidth-1:0] StartupReset = CountWidth'(25);

    // register indexes of the configuration port
    localparam logic [CfgIdxWidth-1:0] CFG_REFERENCE_SCALE = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_ON_THRESHOLD    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_OFF_THRESHOLD   = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_STARTUP_SAMPLES = 2'd3;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_STARTUP,
        MODE_READY,
        MODE_FAILURE
    } mode_t;

    // converted word between the input stage and the sequencer stage
    typedef struct packed {
        logic                  valid;
        logic [LevelWidth-1:0] level;
    } stage_t;

    typedef struct packed {
        logic [LevelWidth-1:0] on_threshold;
        logic [LevelWidth-1:0] off_threshold;
        logic [CountWidth-1:0] startup_samples;
    } seq_cfg_t;

endpackage

### hdl/smps_scale.sv
module smps_scale
    import smps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ScaleWidth-1:0] reference_scale,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [AdcWidth-1:0]   adc_sample,
    input  logic                  take,
    output stage_t                stage
);

    localparam int ProdWidth = ScaleWidth + AdcWidth;

    logic                  valid_reg;
    logic                  valid_next;
    logic [LevelWidth-1:0] level_reg;
    logic [ProdWidth-1:0]  product;
    logic [ProdWidth:0]    rounded;
    logic                  load;

    // round(2*scale*raw/4096) == (scale*raw + 1024) >> 11
    assign product = ProdWidth'(reference_scale) * ProdWidth'(adc_sample);
    assign rounded = {1'b0, product} + (ProdWidth+1)'(1024);

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg <= rounded[LevelWidth+10:11];
        end
    end

    assign stage.valid = valid_reg;
    assign stage.level = level_reg;

endmodule

### hdl/smps_seq.sv
module smps_seq
    import smps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  seq_cfg_t              cfg,
    input  stage_t                stage,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            mode,
    output logic                  drive_enable,
    output logic                  reset_asserted,
    output logic [LevelWidth-1:0] filtered_level
);

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [LevelWidth-1:0] avg_reg;
    logic [LevelWidth-1:0] avg_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [CountWidth-1:0] count_inc;
    logic                  drive_reg;
    logic                  drive_next;
    logic                  hold_reg;
    logic                  hold_next;
    logic                  out_valid_reg;
    logic [LevelWidth+1:0] avg_sum;
    logic                  above_on;
    logic                  below_off;

    assign take = stage.valid && (!out_valid_reg || !out_stall);

    // floor((3*avg + sample + 2) / 4)
    assign avg_sum   = (LevelWidth+2)'(avg_reg) * (LevelWidth+2)'(3)
                     + (LevelWidth+2)'(stage.level) + (LevelWidth+2)'(2);
    assign avg_next  = avg_sum[LevelWidth+1:2];
    assign above_on  = avg_next > cfg.on_threshold;
    assign below_off = avg_next < cfg.off_threshold;
    assign count_inc = count_reg + CountWidth'(1);

    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_OFF:
            begin
                if (above_on)
                begin
                    mode_next = MODE_STARTUP;
                end
            end
            MODE_STARTUP:
            begin
                if (below_off)
                begin
                    mode_next = MODE_FAILURE;
                end
                else if (count_inc == cfg.startup_samples)
                begin
                    mode_next = MODE_READY;
                end
            end
            MODE_READY:
            begin
                if (below_off)
                begin
                    mode_next = MODE_FAILURE;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb
    begin
        drive_next = drive_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        case (mode_reg)
            MODE_OFF:
            begin
                if (above_on)
                begin
                    drive_next = 1'b1;
                end
            end
            MODE_STARTUP:
            begin
                if (below_off)
                begin
                    drive_next = 1'b0;
                end
                else
                begin
                    count_next = count_inc;
                    if (count_inc == cfg.startup_samples)
                    begin
                        hold_next = 1'b0;
                    end
                end
            end
            MODE_READY:
            begin
                if (below_off)
                begin
                    drive_next = 1'b0;
                    hold_next  = 1'b1;
                end
            end
            default:
            begin
                drive_next = drive_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            avg_reg       <= '0;
            count_reg     <= '0;
            drive_reg     <= 1'b0;
            hold_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                avg_reg   <= avg_next;
                count_reg <= count_next;
                drive_reg <= drive_next;
                hold_reg  <= hold_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // the state registers double as the result word
    assign out_valid      = out_valid_reg;
    assign mode           = mode_reg;
    assign drive_enable   = drive_reg;
    assign reset_asserted = hold_reg;
    assign filtered_level = avg_reg;

endmodule

### hdl/supply_monitor_power_sequencer_core.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------------
// input     | in_valid / in_stall       | adc_sample
// result    | out_valid / out_stall     | mode, drive_enable, reset_asserted,
//           |                           | filtered_level
// config    | cfg_write                 | cfg_index, cfg_data
//
// one word per cycle sustained unless the result stalls; input stage, then sequencer registers
// input stage registers the scaled level, one multiply wide
// the average, startup counter and mode update together and feed the result word
// reset: average zero, mode off, drive off, downstream reset held
// a stalled result holds the pipe, the input stage still takes one more word
module supply_monitor_power_sequencer_core
    import smps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]    cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [AdcWidth-1:0]    adc_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             mode,
    output logic                   drive_enable,
    output logic                   reset_asserted,
    output logic [LevelWidth-1:0]  filtered_level
);

    logic [ScaleWidth-1:0] scale_reg;
    seq_cfg_t              cfg_reg;
    stage_t                stage;
    logic                  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg               <= ScaleReset;
            cfg_reg.on_threshold    <= OnThrReset;
            cfg_reg.off_threshold   <= OffThrReset;
            cfg_reg.startup_samples <= StartupReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REFERENCE_SCALE: scale_reg <= cfg_data[ScaleWidth-1:0];
                CFG_ON_THRESHOLD:    cfg_reg.on_threshold <= cfg_data[LevelWidth-1:0];
                CFG_OFF_THRESHOLD:   cfg_reg.off_threshold <= cfg_data[LevelWidth-1:0];
                CFG_STARTUP_SAMPLES: cfg_reg.startup_samples <= cfg_data[CountWidth-1:0];
                default:             scale_reg <= scale_reg;
            endcase
        end
    end

    smps_scale u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .reference_scale (scale_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .adc_sample      (adc_sample),
        .take            (take),
        .stage           (stage)
    );

    smps_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .stage          (stage),
        .take           (take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mode           (mode),
        .drive_enable   (drive_enable),
        .reset_asserted (reset_asserted),
        .filtered_level (filtered_level)
    );

    // failure only leaves through reset
    a_failure_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (mode == MODE_FAILURE) |=> (mode == MODE_FAILURE))
        else $error("failure mode left without reset");

    a_ready_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (mode == MODE_READY) |-> (drive_enable && !reset_asserted))
        else $error("ready mode with wrong drive or reset");

    a_idle_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (mode == MODE_OFF || mode == MODE_FAILURE) |-> (!drive_enable && reset_asserted))
        else $error("off or failure mode with drive on or reset released");

    // input only backs up when the result word is stuck
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result side is free");

endmodule
